// ===== rtl/rmq_pkg.sv =====
// Package: shared types and constants for the rotation matrix to quaternion core.
package rmq_pkg;

  localparam int unsigned ElemW   = 32;
  localparam int unsigned ArgW    = 36;   // root argument, Q.30, non-negative
  localparam int unsigned RadW    = 66;   // argument << 30
  localparam int unsigned RootW   = 33;   // floor(sqrt(radicand))
  localparam int unsigned NumW    = 35;   // signed off-diagonal numerator
  localparam int unsigned MagW    = 34;   // numerator magnitude
  localparam int unsigned DivW    = 63;   // magnitude << 29
  localparam int unsigned QuotW   = 63;
  localparam int unsigned SqrtSteps = 33;
  localparam int unsigned DivSteps  = 63;
  localparam logic signed [ArgW-1:0] OneQ30 = ArgW'(64'sd1073741824);

  typedef logic signed [ElemW-1:0] elem_t;

  typedef struct packed {
    elem_t m_00; elem_t m_01; elem_t m_02;
    elem_t m_10; elem_t m_11; elem_t m_12;
    elem_t m_20; elem_t m_21; elem_t m_22;
  } mat_t;

  typedef struct packed {
    elem_t quat_x; elem_t quat_y; elem_t quat_z; elem_t quat_w;
    logic  degenerate;
  } quat_t;

  // Per-item control through the pipeline.
  typedef struct packed {
    logic [1:0] root_idx;   // 0..2 = x,y,z ; 3 = w
    logic       degenerate;
  } ctl_t;

  localparam logic [1:0] IdxX = 2'd0;
  localparam logic [1:0] IdxY = 2'd1;
  localparam logic [1:0] IdxZ = 2'd2;
  localparam logic [1:0] IdxW = 2'd3;

  function automatic elem_t sat_out(input logic neg, input logic [QuotW-1:0] mag);
    elem_t r;
    if (neg) begin
      if (mag >= QuotW'(64'h8000_0000)) r = elem_t'(32'h8000_0000);
      else r = elem_t'(-$signed({1'b0, mag[ElemW-1:0]}));
    end else begin
      if (mag > QuotW'(64'h7FFF_FFFF)) r = elem_t'(32'h7FFF_FFFF);
      else r = elem_t'(mag[ElemW-1:0]);
    end
    return r;
  endfunction

endpackage

// ===== rtl/rmq_if.sv =====
// Interface: valid/ready channel carrying one payload item.
interface rmq_if #(parameter type payload_t = logic) (input logic clk);
  logic     valid;
  logic     ready;
  payload_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== rtl/rmq_front.sv =====
// Front stage: branch select, root argument and the three numerators.
module rmq_front
  import rmq_pkg::*;
(
  input  mat_t                    m,
  output logic [ArgW-1:0]         arg,
  output logic signed [NumW-1:0]  num_a,   // w or cyclic first
  output logic signed [NumW-1:0]  num_b,
  output logic signed [NumW-1:0]  num_c,
  output ctl_t                    ctl
);
  logic signed [ArgW-1:0] tr, a;
  logic signed [ArgW-1:0] d0, d1, d2;
  logic [1:0] i;
  logic signed [NumW-1:0] s01, s02, s12, d10, d21, d02;

  always_comb begin
    d0 = ArgW'(m.m_00);
    d1 = ArgW'(m.m_11);
    d2 = ArgW'(m.m_22);
    tr = d0 + d1 + d2 + OneQ30;
    s01 = NumW'(m.m_01) + NumW'(m.m_10);
    s02 = NumW'(m.m_02) + NumW'(m.m_20);
    s12 = NumW'(m.m_12) + NumW'(m.m_21);
    d21 = NumW'(m.m_21) - NumW'(m.m_12);
    d02 = NumW'(m.m_02) - NumW'(m.m_20);
    d10 = NumW'(m.m_10) - NumW'(m.m_01);
    i = IdxX;
    if (m.m_11 > m.m_00) i = IdxY;
    if (m.m_22 > ((i == IdxY) ? m.m_11 : m.m_00)) i = IdxZ;
    ctl.degenerate = 1'b0;
    if (tr > 0) begin
      a = tr;
      ctl.root_idx = IdxW;
      num_a = d21; num_b = d02; num_c = d10;        // x, y, z
    end else begin
      ctl.root_idx = i;
      case (i)
        IdxX: begin a = d0 - (d1 + d2) + OneQ30; num_a = d21; num_b = s01; num_c = s02; end
        IdxY: begin a = d1 - (d2 + d0) + OneQ30; num_a = d02; num_b = s12; num_c = s01; end
        default: begin a = d2 - (d0 + d1) + OneQ30; num_a = d10; num_b = s02; num_c = s12; end
      endcase
      if (a < 0) begin
        a = '0;
        ctl.degenerate = 1'b1;
      end
    end
    arg = a;
  end
endmodule

// ===== rtl/rmq_sqrt_stage.sv =====
// One registered step of the restoring square root.
module rmq_sqrt_stage
  import rmq_pkg::*;
#(parameter int unsigned Step = 0)
(
  input  logic             clk,
  input  logic             en,
  input  logic [RadW-1:0]  rem_in,
  input  logic [RootW-1:0] root_in,
  output logic [RadW-1:0]  rem_out,
  output logic [RootW-1:0] root_out
);
  localparam int unsigned Sh = 2 * (SqrtSteps - 1 - Step);
  logic [RadW+1:0] trial;
  logic [RadW+1:0] rem_w;

  always_comb begin
    trial = ({2'b0, root_in, 2'b01} << Sh);
    rem_w = {2'b0, rem_in};
  end

  always_ff @(posedge clk) begin
    if (en) begin
      if (rem_w >= trial) begin
        rem_out  <= RadW'(rem_w - trial);
        root_out <= {root_in[RootW-2:0], 1'b1};
      end else begin
        rem_out  <= rem_in;
        root_out <= {root_in[RootW-2:0], 1'b0};
      end
    end
  end
endmodule

// ===== rtl/rmq_div_stage.sv =====
// One registered step of three parallel restoring dividers.
module rmq_div_stage
  import rmq_pkg::*;
#(parameter int unsigned Step = 0)
(
  input  logic             clk,
  input  logic             en,
  input  logic [RootW-1:0] den,
  input  logic [3*(RootW+1)-1:0] rem_in,
  input  logic [3*DivW-1:0]      dvd_in,
  output logic [3*(RootW+1)-1:0] rem_out,
  output logic [3*DivW-1:0]      dvd_out
);
  logic [RootW+1:0] t [3];
  always_comb begin
    for (int n = 0; n < 3; n++)
      t[n] = {rem_in[n*(RootW+1) +: RootW+1], dvd_in[n*DivW + DivW-1]};
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int n = 0; n < 3; n++) begin
        if (t[n] >= {2'b0, den}) begin
          rem_out[n*(RootW+1) +: RootW+1] <= (RootW+1)'(t[n] - {2'b0, den});
          dvd_out[n*DivW +: DivW] <= {dvd_in[n*DivW +: DivW-1], 1'b1};
        end else begin
          rem_out[n*(RootW+1) +: RootW+1] <= t[n][RootW:0];
          dvd_out[n*DivW +: DivW] <= {dvd_in[n*DivW +: DivW-1], 1'b0};
        end
      end
    end
  end
endmodule

// ===== rtl/rotation_matrix_to_quaternion_core.sv =====
// Top level: pipelined rotation matrix to quaternion (Shoemake) converter.
// Pipeline: 1 + 33 + 63 + 1 = 98 register stages (front, root, divider, output).
// Throughput: one item per cycle unless stalled; set by the bit-per-stage root and divider chains.
// A stall freezes the whole pipeline; the output register holds until taken.
// Reset (rst, synchronous) clears all valid bits; payload registers are not reset.
module rotation_matrix_to_quaternion_core
  import rmq_pkg::*;
(
  input  logic clk,
  input  logic rst,
  rmq_if.sink   in_ch,
  rmq_if.source out_ch
);
  localparam int unsigned Depth = 1 + SqrtSteps + DivSteps;
  localparam int unsigned SignW = 3;

  logic en;
  logic [Depth-1:0] vld;

  assign en = !out_ch.valid || out_ch.ready;
  assign in_ch.ready = en;

  // Stage 0
  logic [ArgW-1:0] f_arg;
  logic signed [NumW-1:0] f_a, f_b, f_c;
  ctl_t f_ctl;
  mat_t m_in;
  assign m_in = in_ch.data;

  rmq_front u_front (.m(m_in), .arg(f_arg), .num_a(f_a), .num_b(f_b), .num_c(f_c), .ctl(f_ctl));

  logic [ArgW-1:0] r0_arg;
  logic [3*MagW-1:0] r0_mag;
  logic [SignW-1:0] r0_sgn;
  ctl_t r0_ctl;
  always_ff @(posedge clk) begin
    if (en) begin
      r0_arg <= f_arg;
      r0_ctl <= f_ctl;
      r0_sgn <= {f_c[NumW-1], f_b[NumW-1], f_a[NumW-1]};
      r0_mag[0*MagW +: MagW] <= MagW'(f_a[NumW-1] ? -f_a : f_a);
      r0_mag[1*MagW +: MagW] <= MagW'(f_b[NumW-1] ? -f_b : f_b);
      r0_mag[2*MagW +: MagW] <= MagW'(f_c[NumW-1] ? -f_c : f_c);
    end
  end

  // Square root chain, side data delayed alongside.
  logic [RadW-1:0]  sq_rem [SqrtSteps+1];
  logic [RootW-1:0] sq_root [SqrtSteps+1];
  logic [3*MagW-1:0] sq_mag [SqrtSteps+1];
  logic [SignW-1:0] sq_sgn [SqrtSteps+1];
  ctl_t sq_ctl [SqrtSteps+1];

  assign sq_rem[0]  = {r0_arg, 30'b0};
  assign sq_root[0] = '0;
  assign sq_mag[0]  = r0_mag;
  assign sq_sgn[0]  = r0_sgn;
  assign sq_ctl[0]  = r0_ctl;

  for (genvar g = 0; g < SqrtSteps; g++) begin : g_sqrt
    rmq_sqrt_stage #(.Step(g)) u_sq (
      .clk(clk), .en(en), .rem_in(sq_rem[g]), .root_in(sq_root[g]),
      .rem_out(sq_rem[g+1]), .root_out(sq_root[g+1]));
    always_ff @(posedge clk) begin
      if (en) begin
        sq_mag[g+1] <= sq_mag[g];
        sq_sgn[g+1] <= sq_sgn[g];
        sq_ctl[g+1] <= sq_ctl[g];
      end
    end
  end

  // Divider chain.
  logic [3*(RootW+1)-1:0] dv_rem [DivSteps+1];
  logic [3*DivW-1:0] dv_dvd [DivSteps+1];
  logic [RootW-1:0] dv_den [DivSteps+1];
  logic [SignW-1:0] dv_sgn [DivSteps+1];
  ctl_t dv_ctl [DivSteps+1];

  assign dv_rem[0] = '0;
  assign dv_den[0] = sq_root[SqrtSteps];
  assign dv_sgn[0] = sq_sgn[SqrtSteps];
  assign dv_ctl[0] = sq_ctl[SqrtSteps];
  for (genvar n = 0; n < 3; n++) begin : g_dvd
    assign dv_dvd[0][n*DivW +: DivW] = {sq_mag[SqrtSteps][n*MagW +: MagW], 29'b0};
  end

  for (genvar g = 0; g < DivSteps; g++) begin : g_div
    rmq_div_stage #(.Step(g)) u_dv (
      .clk(clk), .en(en), .den(dv_den[g]), .rem_in(dv_rem[g]), .dvd_in(dv_dvd[g]),
      .rem_out(dv_rem[g+1]), .dvd_out(dv_dvd[g+1]));
    always_ff @(posedge clk) begin
      if (en) begin
        dv_den[g+1] <= dv_den[g];
        dv_sgn[g+1] <= dv_sgn[g];
        dv_ctl[g+1] <= dv_ctl[g];
      end
    end
  end

  // Output assembly.
  logic [RootW-1:0] s_fin;
  elem_t root_q, qa, qb, qc;
  quat_t q_next, q_reg;
  ctl_t c_fin;
  logic [SignW-1:0] sg_fin;

  always_comb begin
    s_fin  = dv_den[DivSteps];
    c_fin  = dv_ctl[DivSteps];
    sg_fin = dv_sgn[DivSteps];
    root_q = sat_out(1'b0, QuotW'(s_fin >> 1));
    if (s_fin == '0) begin
      qa = '0; qb = '0; qc = '0;
    end else begin
      qa = sat_out(sg_fin[0], dv_dvd[DivSteps][0*DivW +: DivW]);
      qb = sat_out(sg_fin[1], dv_dvd[DivSteps][1*DivW +: DivW]);
      qc = sat_out(sg_fin[2], dv_dvd[DivSteps][2*DivW +: DivW]);
    end
    q_next.degenerate = c_fin.degenerate;
    case (c_fin.root_idx)
      IdxW: begin q_next.quat_w = root_q; q_next.quat_x = qa; q_next.quat_y = qb; q_next.quat_z = qc; end
      IdxX: begin q_next.quat_x = root_q; q_next.quat_w = qa; q_next.quat_y = qb; q_next.quat_z = qc; end
      IdxY: begin q_next.quat_y = root_q; q_next.quat_w = qa; q_next.quat_z = qb; q_next.quat_x = qc; end
      default: begin q_next.quat_z = root_q; q_next.quat_w = qa; q_next.quat_x = qb; q_next.quat_y = qc; end
    endcase
  end

  logic out_vld;
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
      out_vld <= 1'b0;
    end else if (en) begin
      vld <= {vld[Depth-2:0], in_ch.valid};
      out_vld <= vld[Depth-1];
    end
  end
  always_ff @(posedge clk) begin
    if (en) q_reg <= q_next;
  end

  assign out_ch.valid = out_vld;
  assign out_ch.data  = q_reg;

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_ch.valid && !out_ch.ready |=> out_ch.valid && $stable(out_ch.data))
    else $error("output item changed while stalled");
  a_deg_root: assert property (@(posedge clk) disable iff (rst)
    out_ch.valid && out_ch.data.degenerate |-> out_ch.data.quat_x == '0 || out_ch.data.quat_y == '0
      || out_ch.data.quat_z == '0)
    else $error("degenerate item with nonzero root component");
  a_freeze: assert property (@(posedge clk) disable iff (rst)
    !en |=> $stable(vld))
    else $error("pipeline moved while stalled");
endmodule
